/* rtl/mdmc_pkg.sv */
`timescale 1ns / 1ps

package mdmc_pkg;

   typedef enum logic [1:0] {
      OP_MIX   = 2'd0,
      OP_MOVE  = 2'd1,
      OP_TURN  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_LEAD_SLOWDOWN  = 2'd0,
      CSR_STOP_MARGIN    = 2'd1,
      CSR_TURN_TOLERANCE = 2'd2
   } csr_index_type;

   localparam logic [6:0] LEAD_SLOWDOWN_RESET  = 7'd35;
   localparam logic [9:0] STOP_MARGIN_RESET    = 10'd30;
   localparam logic [9:0] TURN_TOLERANCE_RESET = 10'd10;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [7:0]  stick_strafe;
      logic signed [7:0]  stick_turn;
      logic signed [7:0]  stick_forward;
      logic signed [23:0] target_forward_or_angle;
      logic signed [23:0] target_side;
      logic [6:0]         speed;
      logic               turn_right;
      logic signed [31:0] enc_back_left;
      logic signed [31:0] enc_back_right;
      logic signed [31:0] enc_front_left;
      logic signed [15:0] gyro_heading;
   } req_type;

   typedef struct packed {
      logic signed [7:0] drive_front_right;
      logic signed [7:0] drive_back_right;
      logic signed [7:0] drive_front_left;
      logic signed [7:0] drive_back_left;
      logic              busy_res;
   } rsp_type;

   typedef struct packed {
      logic [6:0] lead_slowdown;
      logic [9:0] stop_margin;
      logic [9:0] turn_tolerance;
   } cfg_type;

endpackage

/* rtl/mdmc_ctrl.sv */
`timescale 1ns / 1ps

module mdmc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  mdmc_pkg::req_type item,
   input  mdmc_pkg::cfg_type cfg,
   output mdmc_pkg::rsp_type result
);

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_FWD  = 4'b0010,
      PH_SIDE = 4'b0100,
      PH_TURN = 4'b1000
   } phase_type;

   localparam logic signed [29:0] HEAD_MAX = 30'sd524287;
   localparam logic signed [29:0] HEAD_MIN = -30'sd524288;

   phase_type          phase_ff, phase_in;
   logic signed [31:0] base_bl_ff, base_bl_in;
   logic signed [31:0] base_br_ff, base_br_in;
   logic signed [31:0] base_fl_ff, base_fl_in;
   logic signed [23:0] goal_fwd_ff, goal_fwd_in;
   logic signed [23:0] goal_side_ff, goal_side_in;
   logic [6:0]         speed_ff, speed_in;
   logic signed [19:0] goal_head_ff, goal_head_in;
   logic               spin_right_ff, spin_right_in;

   logic signed [33:0] dist_bl, dist_br, dist_fl;
   logic signed [33:0] lim_fwd, lim_side;
   logic signed [7:0]  spd, slowed;
   logic signed [29:0] angle_x10, head_raw;
   logic signed [33:0] head_err;
   logic signed [9:0]  fr, br, fl, bl;

   function automatic logic signed [33:0] abs34(input logic signed [33:0] v);
      abs34 = (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
      logic signed [7:0] r;
      if (v > 10'sd127) begin
         r = 8'sd127;
      end else if (v < -10'sd127) begin
         r = -8'sd127;
      end else begin
         r = v[7:0];
      end
      sat8 = r;
   endfunction

   function automatic logic signed [9:0] dir10(input logic signed [7:0] v, input logic neg);
      dir10 = neg ? -10'(v) : 10'(v);
   endfunction

   // Distances travelled since the baselines, computed without wrap.
   assign dist_bl = abs34(34'(item.enc_back_left) - 34'(base_bl_ff));
   assign dist_br = abs34(34'(item.enc_back_right) - 34'(base_br_ff));
   assign dist_fl = abs34(34'(item.enc_front_left) - 34'(base_fl_ff));
   assign lim_fwd  = abs34(34'(goal_fwd_ff)) - 34'(cfg.stop_margin);
   assign lim_side = abs34(34'(goal_side_ff)) - 34'(cfg.stop_margin);

   assign spd    = {1'b0, speed_ff};
   assign slowed = spd - {1'b0, cfg.lead_slowdown};

   assign angle_x10 = (30'(item.target_forward_or_angle) <<< 3)
                    + (30'(item.target_forward_or_angle) <<< 1);
   assign head_raw  = item.turn_right ? 30'(item.gyro_heading) - angle_x10
                                      : 30'(item.gyro_heading) + angle_x10;
   assign head_err  = abs34(34'(item.gyro_heading) - 34'(goal_head_ff));

   always_comb begin
      phase_in      = phase_ff;
      base_bl_in    = base_bl_ff;
      base_br_in    = base_br_ff;
      base_fl_in    = base_fl_ff;
      goal_fwd_in   = goal_fwd_ff;
      goal_side_in  = goal_side_ff;
      speed_in      = speed_ff;
      goal_head_in  = goal_head_ff;
      spin_right_in = spin_right_ff;
      fr = '0;
      br = '0;
      fl = '0;
      bl = '0;
      unique case (mdmc_pkg::op_type'(item.opcode))
         mdmc_pkg::OP_MIX: begin
            phase_in = PH_IDLE;
            fr = 10'(item.stick_forward) - 10'(item.stick_turn) - 10'(item.stick_strafe);
            br = 10'(item.stick_forward) - 10'(item.stick_turn) + 10'(item.stick_strafe);
            fl = 10'(item.stick_forward) + 10'(item.stick_turn) + 10'(item.stick_strafe);
            bl = 10'(item.stick_forward) + 10'(item.stick_turn) - 10'(item.stick_strafe);
         end
         mdmc_pkg::OP_MOVE: begin
            base_bl_in   = item.enc_back_left;
            base_br_in   = item.enc_back_right;
            base_fl_in   = item.enc_front_left;
            goal_fwd_in  = item.target_forward_or_angle;
            goal_side_in = item.target_side;
            speed_in     = item.speed;
            if (item.target_forward_or_angle != '0) begin
               phase_in = PH_FWD;
            end else if (item.target_side != '0) begin
               phase_in = PH_SIDE;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         mdmc_pkg::OP_TURN: begin
            if (head_raw > HEAD_MAX) begin
               goal_head_in = HEAD_MAX[19:0];
            end else if (head_raw < HEAD_MIN) begin
               goal_head_in = HEAD_MIN[19:0];
            end else begin
               goal_head_in = head_raw[19:0];
            end
            speed_in      = item.speed;
            spin_right_in = item.turn_right;
            phase_in      = PH_TURN;
         end
         mdmc_pkg::OP_TICK: begin
            unique case (phase_ff)
               PH_FWD: begin
                  if (dist_bl < lim_fwd || dist_br < lim_fwd) begin
                     // The side that has gone farther is slowed down.
                     fr = dir10((dist_bl < dist_br) ? slowed : spd, !(goal_fwd_ff > 0));
                     br = fr;
                     fl = dir10((dist_bl > dist_br) ? slowed : spd, !(goal_fwd_ff > 0));
                     bl = fl;
                  end else if (goal_side_ff != '0) begin
                     base_bl_in = item.enc_back_left;
                     base_fl_in = item.enc_front_left;
                     phase_in   = PH_SIDE;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_SIDE: begin
                  if (dist_bl < lim_side && dist_fl < lim_side) begin
                     fl = dir10((dist_bl < dist_fl) ? slowed : spd, !(goal_side_ff > 0));
                     br = dir10((dist_bl > dist_fl) ? slowed : spd, !(goal_side_ff > 0));
                     fr = -fl;
                     bl = -br;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_TURN: begin
                  if (head_err > 34'(cfg.turn_tolerance)) begin
                     fr = dir10(spd, spin_right_ff);
                     br = fr;
                     fl = -fr;
                     bl = -fr;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      endcase
   end

   assign result.drive_front_right = sat8(fr);
   assign result.drive_back_right  = sat8(br);
   assign result.drive_front_left  = sat8(fl);
   assign result.drive_back_left   = sat8(bl);
   assign result.busy_res          = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_bl_ff    <= '0;
         base_br_ff    <= '0;
         base_fl_ff    <= '0;
         goal_fwd_ff   <= '0;
         goal_side_ff  <= '0;
         speed_ff      <= '0;
         goal_head_ff  <= '0;
         spin_right_ff <= 1'b0;
      end else if (advance) begin
         base_bl_ff    <= base_bl_in;
         base_br_ff    <= base_br_in;
         base_fl_ff    <= base_fl_in;
         goal_fwd_ff   <= goal_fwd_in;
         goal_side_ff  <= goal_side_in;
         speed_ff      <= speed_in;
         goal_head_ff  <= goal_head_in;
         spin_right_ff <= spin_right_in;
      end
   end

endmodule

/* rtl/mecanum_drive_move_controller.sv */
`timescale 1ns / 1ps

// Channel   Ports                              Direction  Content
// req       req_valid/req_ready/req_data       in         sensor and command transaction
// rsp       rsp_valid/rsp_ready/rsp_data       out        four motor drives and busy flag
// csr       csr_valid/csr_ready/csr_index/data in         register write, always ready
//
// A transaction is taken into the input register, evaluated against the controller
// state in one pass and written to the result register. One transaction is taken
// every cycle unless the rsp side stalls. The state update happens as the
// transaction moves into the result register. A stalled rsp side holds the result
// register and a full input register; req_ready drops only when both are full.
// Reset clears the valid flags and phase and resets the state and csr registers.

module mecanum_drive_move_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdmc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdmc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_data
);

   mdmc_pkg::cfg_type cfg_ff;
   mdmc_pkg::req_type item_ff;
   logic              item_valid_ff;
   mdmc_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   mdmc_pkg::rsp_type result;
   logic              out_free;
   logic              advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_slowdown  <= mdmc_pkg::LEAD_SLOWDOWN_RESET;
         cfg_ff.stop_margin    <= mdmc_pkg::STOP_MARGIN_RESET;
         cfg_ff.turn_tolerance <= mdmc_pkg::TURN_TOLERANCE_RESET;
      end else if (csr_valid) begin
         unique case (mdmc_pkg::csr_index_type'(csr_index))
            mdmc_pkg::CSR_LEAD_SLOWDOWN:  cfg_ff.lead_slowdown  <= csr_data[6:0];
            mdmc_pkg::CSR_STOP_MARGIN:    cfg_ff.stop_margin    <= csr_data;
            mdmc_pkg::CSR_TURN_TOLERANCE: cfg_ff.turn_tolerance <= csr_data;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   mdmc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

endmodule
